### sv/dmxfb_pkg.sv
// ----------------------------------------------------------------------------
// dmxfb_pkg
// Shared types and constants for the DMX signal-loss fade buffer.
// ----------------------------------------------------------------------------
package dmxfb_pkg;

    localparam int CHANNELS_DEF = 512;

    localparam int CHAN_W  = 9;
    localparam int LEVEL_W = 8;
    localparam int MS_W    = 16;
    localparam int MODE_W  = 2;
    localparam int OP_W    = 2;
    localparam int CFG_IDX_W = 2;

    localparam logic [MS_W-1:0] TIMEOUT_RST = 16'd3000;
    localparam logic [MS_W-1:0] FADE_RST    = 16'd2000;
    localparam logic [MS_W-1:0] MS_MAX      = 16'hFFFF;

    typedef enum logic [OP_W-1:0] {
        OP_WRITE = 2'd0,
        OP_TICK  = 2'd1,
        OP_READ  = 2'd2,
        OP_RSVD  = 2'd3
    } t_opcode;

    typedef enum logic [MODE_W-1:0] {
        MODE_NONE  = 2'd0,
        MODE_LIVE  = 2'd1,
        MODE_FADE  = 2'd2,
        MODE_BLACK = 2'd3
    } t_mode;

    localparam logic [CFG_IDX_W-1:0] CFG_TIMEOUT = 2'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_FADE    = 2'd1;

    typedef enum logic [2:0] {
        ST_CLEAR,
        ST_IDLE,
        ST_LOAD,
        ST_DIV,
        ST_OUT
    } t_state;

    typedef struct packed {
        logic               done;
        logic [LEVEL_W-1:0] quo;
    } t_div_stat;

endpackage

### sv/dmxfb_store.sv
// ----------------------------------------------------------------------------
// dmxfb_store
// Channel level memory with one write and one registered read port, and a
// clearing pass after reset that zeroes one entry per cycle.
// ----------------------------------------------------------------------------
module dmxfb_store #(
    parameter int DEPTH = 512,
    parameter int AW    = 9
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_we,
    input  logic [AW-1:0]                i_waddr,
    input  logic [dmxfb_pkg::LEVEL_W-1:0] i_wdata,
    input  logic [AW-1:0]                i_raddr,
    output logic [dmxfb_pkg::LEVEL_W-1:0] o_rdata,
    output logic                         o_clr_busy
);

    logic [dmxfb_pkg::LEVEL_W-1:0] r_mem [DEPTH];
    logic [AW-1:0]                 r_clr_addr;
    logic                          r_clr_busy;
    logic [dmxfb_pkg::LEVEL_W-1:0] r_rdata;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_clr_busy <= 1'b1;
            r_clr_addr <= '0;
        end else if (r_clr_busy) begin
            if (r_clr_addr == AW'(DEPTH - 1)) begin
                r_clr_busy <= 1'b0;
            end
            r_clr_addr <= r_clr_addr + 1'b1;
        end
    end

    always_ff @(posedge i_clk) begin
        if (r_clr_busy) begin
            r_mem[r_clr_addr] <= '0;
        end else if (i_we) begin
            r_mem[i_waddr] <= i_wdata;
        end
        r_rdata <= r_mem[i_raddr];
    end

    assign o_rdata    = r_rdata;
    assign o_clr_busy = r_clr_busy;

endmodule

### sv/dmxfb_div.sv
// ----------------------------------------------------------------------------
// dmxfb_div
// Fade scaler: registers level * left, then a restoring divide by the fade
// length, one quotient bit per cycle through one compare/subtract unit.
// ----------------------------------------------------------------------------
module dmxfb_div (
    input  logic                          i_clk,
    input  logic                          i_rst_n,
    input  logic                          i_start,
    input  logic [dmxfb_pkg::LEVEL_W-1:0] i_level,
    input  logic [dmxfb_pkg::MS_W-1:0]    i_left,
    input  logic [dmxfb_pkg::MS_W-1:0]    i_divisor,
    output dmxfb_pkg::t_div_stat          o_stat
);

    localparam int PROD_W = dmxfb_pkg::LEVEL_W + dmxfb_pkg::MS_W;
    localparam int CNT_W  = $clog2(dmxfb_pkg::LEVEL_W);

    logic                          r_busy;
    logic                          r_done;
    logic [CNT_W-1:0]              r_cnt;
    logic [dmxfb_pkg::MS_W-1:0]    r_rem;
    logic [dmxfb_pkg::LEVEL_W-1:0] r_dq;

    logic [PROD_W-1:0]             w_prod;
    logic [dmxfb_pkg::MS_W:0]      w_trial;
    logic                          w_ge;
    logic [dmxfb_pkg::MS_W:0]      w_diff;

    // Quotient fits in LEVEL_W bits since left <= divisor, so the high part
    // of the product is already below the divisor.
    assign w_prod  = PROD_W'(i_level) * PROD_W'(i_left);
    assign w_trial = {r_rem, r_dq[dmxfb_pkg::LEVEL_W-1]};
    assign w_ge    = w_trial >= {1'b0, i_divisor};
    assign w_diff  = w_trial - {1'b0, i_divisor};

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
            r_cnt  <= '0;
        end else begin
            r_done <= r_busy && (r_cnt == CNT_W'(dmxfb_pkg::LEVEL_W - 1));
            if (i_start) begin
                r_busy <= 1'b1;
                r_cnt  <= '0;
            end else if (r_busy) begin
                if (r_cnt == CNT_W'(dmxfb_pkg::LEVEL_W - 1)) begin
                    r_busy <= 1'b0;
                end
                r_cnt <= r_cnt + 1'b1;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem <= w_prod[PROD_W-1:dmxfb_pkg::LEVEL_W];
            r_dq  <= w_prod[dmxfb_pkg::LEVEL_W-1:0];
        end else if (r_busy) begin
            r_rem <= w_ge ? w_diff[dmxfb_pkg::MS_W-1:0] : w_trial[dmxfb_pkg::MS_W-1:0];
            r_dq  <= {r_dq[dmxfb_pkg::LEVEL_W-2:0], w_ge};
        end
    end

    assign o_stat.done = r_done;
    assign o_stat.quo  = r_dq;

endmodule

### sv/dmx_signal_loss_fade_buffer_top.sv
// ----------------------------------------------------------------------------
// dmx_signal_loss_fade_buffer_top
// Hold-last-look DMX frame buffer with a linear fade to black on signal loss.
// ----------------------------------------------------------------------------
// Usage:
//   Input stream carries one item per write, tick or read: tuser is the
//   opcode, tlast the frame end flag, tdata the channel and level. Every
//   item gives one result on the output stream: tdata the level shown on
//   the addressed channel, tuser the mode.
//   Configuration writes (timeout, fade length) go over the cfg channel,
//   which is always ready; write them only while no item is in flight.
//   Items are taken one at a time: a new item is accepted only once the
//   previous result is loaded into the output register. A fade is scaled
//   through an 8-step shift/subtract divider.
//   After reset the frame memory is zeroed one entry per cycle (DEPTH
//   entries, CHANNELS capped at 512); no item is accepted during that pass.
//   The result sits in an output register; the next item is accepted while
//   it waits. A stalled receiver holds the following result inside and
//   stops new items after that.
// ----------------------------------------------------------------------------
module dmx_signal_loss_fade_buffer_top #(
    parameter int CHANNELS = dmxfb_pkg::CHANNELS_DEF
) (
    input  logic                            i_clk,
    input  logic                            i_rst_n,
    input  logic                            i_s_axis_tvalid,
    output logic                            o_s_axis_tready,
    input  logic [23:0]                     i_s_axis_tdata,  // channel, level_in, zero pad
    input  logic [dmxfb_pkg::OP_W-1:0]      i_s_axis_tuser,  // opcode
    input  logic                            i_s_axis_tlast,  // frame_end
    output logic                            o_m_axis_tvalid,
    input  logic                            i_m_axis_tready,
    output logic [dmxfb_pkg::LEVEL_W-1:0]   o_m_axis_tdata,  // level_out
    output logic [dmxfb_pkg::MODE_W-1:0]    o_m_axis_tuser,  // mode
    input  logic                            i_cfg_valid,
    output logic                            o_cfg_ready,
    input  logic [dmxfb_pkg::CFG_IDX_W-1:0] i_cfg_index,
    input  logic [dmxfb_pkg::MS_W-1:0]      i_cfg_data
);

    localparam int DEPTH = (CHANNELS < (1 << dmxfb_pkg::CHAN_W)) ?
                           CHANNELS : (1 << dmxfb_pkg::CHAN_W);
    localparam int AW    = (DEPTH > 1) ? $clog2(DEPTH) : 1;

    dmxfb_pkg::t_state r_state, n_state;

    logic                          r_present;
    logic                          r_fading;
    logic [dmxfb_pkg::MS_W-1:0]    r_since;
    logic [dmxfb_pkg::MS_W-1:0]    r_elapsed;
    logic [dmxfb_pkg::MS_W-1:0]    r_timeout;
    logic [dmxfb_pkg::MS_W-1:0]    r_fade;
    logic                          r_out_valid;

    logic                          r_is_wr;
    logic                          r_ok;
    logic [dmxfb_pkg::LEVEL_W-1:0] r_lvl_in;
    logic [dmxfb_pkg::LEVEL_W-1:0] r_res_level;
    dmxfb_pkg::t_mode              r_res_mode;
    logic [dmxfb_pkg::LEVEL_W-1:0] r_out_level;
    dmxfb_pkg::t_mode              r_out_mode;

    logic [dmxfb_pkg::MS_W-1:0]    n_since;

    logic                          w_accept;
    logic                          w_clr_busy;
    logic [dmxfb_pkg::CHAN_W-1:0]  w_chan;
    logic [dmxfb_pkg::LEVEL_W-1:0] w_lvl_in;
    dmxfb_pkg::t_opcode            w_op;
    logic                          w_chan_ok;
    logic [AW-1:0]                 w_addr;
    logic [dmxfb_pkg::LEVEL_W-1:0] w_rdata;
    logic [dmxfb_pkg::LEVEL_W-1:0] w_level;
    logic                          w_hold;
    logic                          w_black;
    logic                          w_div_start;
    logic                          w_load_res;
    logic                          w_out_load;
    logic [dmxfb_pkg::MS_W-1:0]    w_left;
    dmxfb_pkg::t_div_stat          w_div;

    assign w_chan    = i_s_axis_tdata[dmxfb_pkg::CHAN_W-1:0];
    assign w_lvl_in  = i_s_axis_tdata[dmxfb_pkg::CHAN_W +: dmxfb_pkg::LEVEL_W];
    assign w_op      = dmxfb_pkg::t_opcode'(i_s_axis_tuser);
    assign w_chan_ok = 32'(w_chan) < CHANNELS;
    assign w_addr    = AW'(w_chan);
    assign w_accept  = i_s_axis_tvalid && o_s_axis_tready;
    assign o_cfg_ready = 1'b1;

    dmxfb_store #(
        .DEPTH (DEPTH),
        .AW    (AW)
    ) u_store (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_we       (w_accept && (w_op == dmxfb_pkg::OP_WRITE) && w_chan_ok),
        .i_waddr    (w_addr),
        .i_wdata    (w_lvl_in),
        .i_raddr    (w_addr),
        .o_rdata    (w_rdata),
        .o_clr_busy (w_clr_busy)
    );

    assign w_level = !r_ok ? '0 : (r_is_wr ? r_lvl_in : w_rdata);
    assign w_hold  = !r_fading || (r_fade == '0);
    assign w_black = r_elapsed >= r_fade;
    assign w_left  = r_fade - r_elapsed;

    dmxfb_div u_div (
        .i_clk     (i_clk),
        .i_rst_n   (i_rst_n),
        .i_start   (w_div_start),
        .i_level   (w_level),
        .i_left    (w_left),
        .i_divisor (r_fade),
        .o_stat    (w_div)
    );

    // Sequencer outputs
    always_comb begin
        o_s_axis_tready = 1'b0;
        w_div_start     = 1'b0;
        w_load_res      = 1'b0;
        w_out_load      = 1'b0;
        unique case (r_state)
            dmxfb_pkg::ST_CLEAR: ;
            dmxfb_pkg::ST_IDLE:  o_s_axis_tready = 1'b1;
            dmxfb_pkg::ST_LOAD: begin
                if (r_present && !w_hold && !w_black) begin
                    w_div_start = 1'b1;
                end else begin
                    w_load_res = 1'b1;
                end
            end
            dmxfb_pkg::ST_DIV:   w_load_res = w_div.done;
            dmxfb_pkg::ST_OUT:   w_out_load = !r_out_valid || i_m_axis_tready;
            default: ;
        endcase
    end

    // Sequencer next state
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            dmxfb_pkg::ST_CLEAR: if (!w_clr_busy) n_state = dmxfb_pkg::ST_IDLE;
            dmxfb_pkg::ST_IDLE:  if (w_accept) n_state = dmxfb_pkg::ST_LOAD;
            dmxfb_pkg::ST_LOAD:  n_state = w_div_start ? dmxfb_pkg::ST_DIV : dmxfb_pkg::ST_OUT;
            dmxfb_pkg::ST_DIV:   if (w_div.done) n_state = dmxfb_pkg::ST_OUT;
            dmxfb_pkg::ST_OUT:   if (w_out_load) n_state = dmxfb_pkg::ST_IDLE;
            default:             n_state = dmxfb_pkg::ST_IDLE;
        endcase
    end

    assign n_since = (r_since == dmxfb_pkg::MS_MAX) ? r_since : r_since + 1'b1;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= dmxfb_pkg::ST_CLEAR;
            r_present   <= 1'b0;
            r_fading    <= 1'b0;
            r_since     <= '0;
            r_elapsed   <= '0;
            r_timeout   <= dmxfb_pkg::TIMEOUT_RST;
            r_fade      <= dmxfb_pkg::FADE_RST;
            r_out_valid <= 1'b0;
        end else begin
            r_state <= n_state;
            if (i_cfg_valid && o_cfg_ready) begin
                if (i_cfg_index == dmxfb_pkg::CFG_TIMEOUT) begin
                    r_timeout <= i_cfg_data;
                end else if (i_cfg_index == dmxfb_pkg::CFG_FADE) begin
                    r_fade <= i_cfg_data;
                end
            end
            if (w_accept) begin
                priority if (w_op == dmxfb_pkg::OP_WRITE) begin
                    if (i_s_axis_tlast) begin
                        r_present <= 1'b1;
                        r_since   <= '0;
                        r_fading  <= 1'b0;
                        r_elapsed <= '0;
                    end
                end else if (w_op == dmxfb_pkg::OP_TICK) begin
                    if (r_present) begin
                        r_since <= n_since;
                        if (r_fading) begin
                            if (r_elapsed != dmxfb_pkg::MS_MAX) begin
                                r_elapsed <= r_elapsed + 1'b1;
                            end
                        end else if ((r_timeout != '0) && (n_since >= r_timeout)) begin
                            r_fading  <= 1'b1;
                            r_elapsed <= '0;
                        end
                    end
                end else begin
                end
            end
            if (w_out_load) begin
                r_out_valid <= 1'b1;
            end else if (i_m_axis_tready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_is_wr  <= (w_op == dmxfb_pkg::OP_WRITE);
            r_ok     <= w_chan_ok;
            r_lvl_in <= w_lvl_in;
        end
        if (w_load_res) begin
            if (r_state == dmxfb_pkg::ST_DIV) begin
                r_res_level <= w_div.quo;
                r_res_mode  <= dmxfb_pkg::MODE_FADE;
            end else if (!r_present) begin
                r_res_level <= '0;
                r_res_mode  <= dmxfb_pkg::MODE_NONE;
            end else if (w_hold) begin
                r_res_level <= w_level;
                r_res_mode  <= dmxfb_pkg::MODE_LIVE;
            end else begin
                r_res_level <= '0;
                r_res_mode  <= dmxfb_pkg::MODE_BLACK;
            end
        end
        if (w_out_load) begin
            r_out_level <= r_res_level;
            r_out_mode  <= r_res_mode;
        end
    end

    assign o_m_axis_tvalid = r_out_valid;
    assign o_m_axis_tdata  = r_out_level;
    assign o_m_axis_tuser  = r_out_mode;

`ifndef NO_ASSERTIONS
    a_no_accept_in_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_clr_busy |-> !o_s_axis_tready)
        else $error("item accepted during memory clear");

    a_div_done_in_div: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_div.done |-> (r_state == dmxfb_pkg::ST_DIV))
        else $error("divider finished outside its state");

    a_dark_modes_zero: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_m_axis_tvalid && ((o_m_axis_tuser == dmxfb_pkg::MODE_NONE) ||
                             (o_m_axis_tuser == dmxfb_pkg::MODE_BLACK)))
        |-> (o_m_axis_tdata == '0))
        else $error("nonzero level with no data or faded black");
`endif

endmodule
